/* rtl/distance_constraint_chain_relax_unit_assert.svh */
// ---------------------------------------------------------------------------
// Distance chain assertion macros
// Wrappers for concurrent assertions that drop out of synthesis builds.
// ---------------------------------------------------------------------------
`ifndef DISTANCE_CONSTRAINT_CHAIN_RELAX_UNIT_ASSERT_SVH
`define DISTANCE_CONSTRAINT_CHAIN_RELAX_UNIT_ASSERT_SVH
`ifndef SYNTHESIS
`define DCCR_ASSERT(lbl, clk, rst, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);
`define DCCR_ASSERT_ALWAYS(lbl, clk, prop, msg) \
  lbl: assert property (@(posedge clk) prop) else $error(msg);
`else
`define DCCR_ASSERT(lbl, clk, rst, prop, msg)
`define DCCR_ASSERT_ALWAYS(lbl, clk, prop, msg)
`endif
`endif

/* rtl/dccr_pkg.sv */
// ---------------------------------------------------------------------------
// Distance chain package
// Shared sizes, register codes, sequencer states and unit status type.
// ---------------------------------------------------------------------------
package dccr_pkg;
  localparam int NODE_COUNT = 10;
  localparam int PASS_COUNT = 6;
  localparam int IDX_W = $clog2(NODE_COUNT);
  localparam int PASS_W = (PASS_COUNT > 1) ? $clog2(PASS_COUNT) : 1;
  localparam int CFG_IDX_W = 8;
  localparam int SPACING_MUL = 10;
  localparam logic [31:0] ONE_FX = 32'h0001_0000;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_REST_DISTANCE  = 8'd0,
    CFG_OFFSET_X       = 8'd1,
    CFG_OFFSET_Y       = 8'd2,
    CFG_SPACING_SCALE  = 8'd3
  } cfg_reg_t;

  typedef enum logic [4:0] {
    ST_IDLE, ST_HEADX, ST_HEADY, ST_HEADW, ST_INITM, ST_INITW,
    ST_RDA, ST_RDB, ST_DIFF, ST_SQX, ST_SQY, ST_SQS, ST_SQW,
    ST_MVX, ST_DVX, ST_DVXW, ST_MVY, ST_DVY, ST_DVYW,
    ST_WRB, ST_WRA, ST_ERD, ST_EOUT
  } state_t;

  typedef struct packed {
    logic busy;
    logic done;
  } unit_stat_t;
endpackage

/* rtl/dccr_if.sv */
// ---------------------------------------------------------------------------
// Distance chain channels
// Ready/valid interfaces for the input, result and configuration channels.
// ---------------------------------------------------------------------------
interface dccr_in_if;
  logic        valid;
  logic        ready;
  logic        action;
  logic signed [31:0] anchor_x;
  logic signed [31:0] anchor_y;
  logic signed [31:0] owner_scale_x;
  logic signed [31:0] owner_scale_y;
  modport source (output valid, action, anchor_x, anchor_y, owner_scale_x, owner_scale_y,
                  input ready);
  modport sink (input valid, action, anchor_x, anchor_y, owner_scale_x, owner_scale_y,
                output ready);
endinterface

interface dccr_out_if;
  logic        valid;
  logic        ready;
  logic [5:0]  node_index;
  logic signed [31:0] node_x;
  logic signed [31:0] node_y;
  logic        last_node;
  modport source (output valid, node_index, node_x, node_y, last_node, input ready);
  modport sink (input valid, node_index, node_x, node_y, last_node, output ready);
endinterface

interface dccr_cfg_if;
  logic        valid;
  logic        ready;
  logic [7:0]  index;
  logic [31:0] data;
  modport source (output valid, index, data, input ready);
  modport sink (input valid, index, data, output ready);
endinterface

/* rtl/distance_constraint_chain_relax_unit.sv */
// An initialize writes the head node and then lays out the other nodes before the first node beat.
// A tick relaxes each pair in each pass through a square root and two divisions.
// Each node is read from the memory before its beat is offered, so node beats are not
// back to back; one item is worked on at a time.
// Reset (synchronous, active high) restores the state, counters and configuration registers
// and clears the chain-ready flag; the node memory keeps whatever it holds until written.
// ---------------------------------------------------------------------------
// Distance constraint chain relaxation unit
// Node positions in one memory, relaxed pair by pair through a sequencer.
// ---------------------------------------------------------------------------
`include "distance_constraint_chain_relax_unit_assert.svh"
module distance_constraint_chain_relax_unit (
  input logic clk,
  input logic rst,
  dccr_in_if.sink    in_ch,
  dccr_out_if.source out_ch,
  dccr_cfg_if.sink   cfg_ch
);
  import dccr_pkg::*;

  logic [30:0] rest_distance;
  logic [31:0] offset_x;
  logic [31:0] offset_y;
  logic [31:0] spacing_scale;

  state_t state;
  state_t state_next;

  logic              chain_ready;
  logic              action;
  logic [31:0]       anc_x, anc_y, scl_x, scl_y;
  logic [31:0]       hx, hy;
  logic [IDX_W-1:0]  idx;
  logic [PASS_W-1:0] pass;
  logic [31:0]       a_x, a_y, b_x, b_y;
  logic [31:0]       dx, dy;
  logic [63:0]       sqx;
  logic [31:0]       pair_len;
  logic [31:0]       mx;

  logic [63:0]      mem [NODE_COUNT];
  logic             rd_en, wr_en;
  logic [IDX_W-1:0] rd_addr, wr_addr;
  logic [63:0]      wr_data, rd_q;

  logic signed [31:0] sm_a, sm_b;
  logic signed [63:0] sm_p;
  logic [31:0]        um_a, um_b;
  logic [63:0]        um_p;
  logic [31:0]        sm_fx;

  logic        sq_start, dv_start;
  logic [31:0] sq_root, dv_quo;
  unit_stat_t  sq_stat, dv_stat;

  logic        in_fire, out_fire, cfg_fire, last_idx, last_pass;
  logic [32:0] diff;
  logic [31:0] diff_mag, dx_mag, dy_mag, span, move;
  logic [31:0] nx, ny;

  assign in_fire = in_ch.valid && in_ch.ready;
  assign out_fire = out_ch.valid && out_ch.ready;
  assign cfg_fire = cfg_ch.valid && cfg_ch.ready;
  assign cfg_ch.ready = 1'b1;
  assign last_idx = idx == IDX_W'(NODE_COUNT - 1);
  assign last_pass = pass == PASS_W'(PASS_COUNT - 1);

  assign diff = {2'b00, rest_distance} - {1'b0, pair_len};
  assign diff_mag = diff[32] ? 32'(-diff) : diff[31:0];
  assign dx_mag = dx[31] ? -dx : dx;
  assign dy_mag = dy[31] ? -dy : dy;
  assign span = 32'(32'(idx) * 32'(SPACING_MUL) * {1'b0, rest_distance});
  assign sm_fx = sm_p[47:16];
  assign move = (diff[32] ^ ((state == ST_DVYW) ? dy[31] : dx[31])) ? -dv_quo : dv_quo;

  always_ff @(posedge clk) begin
    if (rst) begin
      rest_distance <= 31'(ONE_FX);
      offset_x <= '0;
      offset_y <= '0;
      spacing_scale <= ONE_FX;
    end else if (cfg_fire) begin
      case (cfg_ch.index)
        CFG_REST_DISTANCE: rest_distance <= cfg_ch.data[30:0];
        CFG_OFFSET_X:      offset_x <= cfg_ch.data;
        CFG_OFFSET_Y:      offset_y <= cfg_ch.data;
        CFG_SPACING_SCALE: spacing_scale <= cfg_ch.data;
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    if (rd_en) begin
      rd_q <= mem[rd_addr];
    end
  end

  always_ff @(posedge clk) begin
    sm_p <= sm_a * sm_b;
    um_p <= um_a * um_b;
  end

  dccr_isqrt u_isqrt (
    .clk(clk), .rst(rst), .start(sq_start), .radicand(sqx + um_p),
    .root(sq_root), .stat(sq_stat)
  );

  dccr_div u_div (
    .clk(clk), .rst(rst), .start(dv_start), .dividend(um_p), .divisor(pair_len),
    .quotient(dv_quo), .stat(dv_stat)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    unique case (state)
      ST_IDLE: begin
        if (in_fire && (in_ch.action || chain_ready)) state_next = ST_HEADX;
      end
      ST_HEADX: state_next = ST_HEADY;
      ST_HEADY: state_next = ST_HEADW;
      ST_HEADW: state_next = action ? ST_INITM : ST_RDA;
      ST_INITM: state_next = ST_INITW;
      ST_INITW: state_next = last_idx ? ST_ERD : ST_INITM;
      ST_RDA:   state_next = ST_RDB;
      ST_RDB:   state_next = ST_DIFF;
      ST_DIFF:  state_next = ST_SQX;
      ST_SQX:   state_next = ST_SQY;
      ST_SQY:   state_next = ST_SQS;
      ST_SQS:   state_next = ST_SQW;
      ST_SQW:   if (sq_stat.done) state_next = ST_MVX;
      ST_MVX:   state_next = ST_DVX;
      ST_DVX:   state_next = ST_DVXW;
      ST_DVXW:  if (dv_stat.done) state_next = ST_MVY;
      ST_MVY:   state_next = ST_DVY;
      ST_DVY:   state_next = ST_DVYW;
      ST_DVYW:  if (dv_stat.done) state_next = ST_WRB;
      ST_WRB: begin
        if (pass != '0) state_next = ST_WRA;
        else if (last_idx && last_pass) state_next = ST_ERD;
        else state_next = ST_RDA;
      end
      ST_WRA:   state_next = (last_idx && last_pass) ? ST_ERD : ST_RDA;
      ST_ERD:   state_next = ST_EOUT;
      ST_EOUT: begin
        if (out_fire) state_next = last_idx ? ST_IDLE : ST_ERD;
      end
      default:  state_next = ST_IDLE;
    endcase
  end

  assign nx = b_x + mx;
  assign ny = b_y + dy;

  always_comb begin
    rd_en = 1'b0;
    rd_addr = idx;
    wr_en = 1'b0;
    wr_addr = idx;
    wr_data = '0;
    sm_a = '0;
    sm_b = '0;
    um_a = '0;
    um_b = '0;
    sq_start = 1'b0;
    dv_start = 1'b0;
    in_ch.ready = 1'b0;
    out_ch.valid = 1'b0;
    unique case (state)
      ST_IDLE:  in_ch.ready = 1'b1;
      ST_HEADX: begin
        sm_a = offset_x;
        sm_b = scl_x;
      end
      ST_HEADY: begin
        sm_a = offset_y;
        sm_b = scl_y;
      end
      ST_HEADW: begin
        wr_en = 1'b1;
        wr_addr = '0;
        wr_data = {hx, anc_y + sm_fx};
      end
      ST_INITM: begin
        sm_a = span;
        sm_b = spacing_scale;
      end
      ST_INITW: begin
        wr_en = 1'b1;
        wr_data = {hx - sm_fx, hy};
      end
      ST_RDA: begin
        rd_en = 1'b1;
        rd_addr = idx - IDX_W'(1);
      end
      ST_RDB:   rd_en = 1'b1;
      ST_SQX: begin
        um_a = dx_mag;
        um_b = dx_mag;
      end
      ST_SQY: begin
        um_a = dy_mag;
        um_b = dy_mag;
      end
      ST_SQS:   sq_start = 1'b1;
      ST_MVX: begin
        um_a = dx_mag;
        um_b = diff_mag;
      end
      ST_DVX:   dv_start = 1'b1;
      ST_MVY: begin
        um_a = dy_mag;
        um_b = diff_mag;
      end
      ST_DVY:   dv_start = 1'b1;
      ST_WRB: begin
        wr_en = 1'b1;
        wr_data = {nx, ny};
      end
      ST_WRA: begin
        wr_en = 1'b1;
        wr_addr = idx - IDX_W'(1);
        wr_data = {a_x - mx, a_y - dy};
      end
      ST_ERD:   rd_en = 1'b1;
      ST_EOUT:  out_ch.valid = 1'b1;
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      chain_ready <= 1'b0;
      idx <= '0;
      pass <= '0;
    end else begin
      unique case (state)
        ST_IDLE: begin
          idx <= IDX_W'(1);
          pass <= '0;
        end
        ST_INITW: begin
          if (last_idx) begin
            chain_ready <= 1'b1;
            idx <= '0;
          end else begin
            idx <= idx + IDX_W'(1);
          end
        end
        ST_WRB, ST_WRA: begin
          if ((state == ST_WRA) || (pass == '0)) begin
            if (last_idx) begin
              if (last_pass) begin
                idx <= '0;
              end else begin
                idx <= IDX_W'(1);
                pass <= pass + PASS_W'(1);
              end
            end else begin
              idx <= idx + IDX_W'(1);
            end
          end
        end
        ST_EOUT: begin
          if (out_fire && !last_idx) idx <= idx + IDX_W'(1);
        end
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    unique case (state)
      ST_IDLE: begin
        action <= in_ch.action;
        anc_x <= in_ch.anchor_x;
        anc_y <= in_ch.anchor_y;
        scl_x <= in_ch.owner_scale_x;
        scl_y <= in_ch.owner_scale_y;
      end
      ST_HEADY: hx <= anc_x + sm_fx;
      ST_HEADW: hy <= anc_y + sm_fx;
      ST_SQX: begin
        b_x <= rd_q[63:32];
        b_y <= rd_q[31:0];
      end
      ST_SQY:   sqx <= um_p;
      ST_SQW: begin
        if (sq_stat.done) begin
          if (sq_root < ONE_FX) begin
            pair_len <= ONE_FX;
            dx <= ONE_FX;
            dy <= '0;
          end else begin
            pair_len <= sq_root;
          end
        end
      end
      ST_DVXW:  if (dv_stat.done) mx <= move;
      ST_DVYW:  if (dv_stat.done) dy <= move;
      default: ;
    endcase
    if (state == ST_RDB) begin
      a_x <= rd_q[63:32];
      a_y <= rd_q[31:0];
    end
    if (state == ST_DIFF) begin
      dx <= rd_q[63:32] - a_x;
      dy <= rd_q[31:0] - a_y;
      b_x <= rd_q[63:32];
      b_y <= rd_q[31:0];
    end
  end

  assign out_ch.node_index = 6'(idx);
  assign out_ch.node_x = rd_q[63:32];
  assign out_ch.node_y = rd_q[31:0];
  assign out_ch.last_node = last_idx;

  `DCCR_ASSERT(a_out_blocks_in, clk, rst, out_ch.valid |-> !in_ch.ready, "result beat while input open")
  `DCCR_ASSERT(a_units_exclusive, clk, rst, !(sq_stat.busy && dv_stat.busy), "units overlap")
  `DCCR_ASSERT(a_last_ends, clk, rst, (out_fire && out_ch.last_node) |=> in_ch.ready, "no idle after last")
  `DCCR_ASSERT_ALWAYS(a_rst_idle, clk, $past(rst) |-> !out_ch.valid, "result beat after reset")
endmodule

/* rtl/dccr_isqrt.sv */
// ---------------------------------------------------------------------------
// Distance chain square root
// Integer square root of a 64-bit value, two radicand bits per cycle.
// ---------------------------------------------------------------------------
module dccr_isqrt (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 start,
  input  logic [63:0]          radicand,
  output logic [31:0]          root,
  output dccr_pkg::unit_stat_t stat
);
  import dccr_pkg::*;

  logic [63:0] v;
  logic [63:0] res;
  logic [63:0] bitv;
  logic [4:0]  count;
  logic        busy;
  logic        done;
  logic [63:0] trial;

  assign trial = res + bitv;

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      count <= '0;
    end else begin
      done <= 1'b0;
      if (start) begin
        busy <= 1'b1;
        count <= '0;
      end else if (busy) begin
        count <= count + 5'd1;
        if (count == 5'd31) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      v <= radicand;
      res <= '0;
      bitv <= 64'h4000_0000_0000_0000;
    end else if (busy) begin
      if (v >= trial) begin
        v <= v - trial;
        res <= (res >> 1) + bitv;
      end else begin
        res <= res >> 1;
      end
      bitv <= bitv >> 2;
    end
  end

  assign root = res[31:0];
  assign stat = '{busy: busy, done: done};
endmodule

/* rtl/dccr_div.sv */
// ---------------------------------------------------------------------------
// Distance chain divider
// Restoring unsigned division of a 64-bit value by a 32-bit value whose
// quotient fits 32 bits, one quotient bit per cycle.
// ---------------------------------------------------------------------------
module dccr_div (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 start,
  input  logic [63:0]          dividend,
  input  logic [31:0]          divisor,
  output logic [31:0]          quotient,
  output dccr_pkg::unit_stat_t stat
);
  import dccr_pkg::*;

  logic [31:0] rem;
  logic [31:0] quo;
  logic [31:0] den;
  logic [4:0]  count;
  logic        busy;
  logic        done;
  logic [32:0] shifted;
  logic        ge;
  logic [32:0] sub;

  assign shifted = {rem, quo[31]};
  assign ge = shifted >= {1'b0, den};
  assign sub = shifted - {1'b0, den};

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      count <= '0;
    end else begin
      done <= 1'b0;
      if (start) begin
        busy <= 1'b1;
        count <= '0;
      end else if (busy) begin
        count <= count + 5'd1;
        if (count == 5'd31) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      rem <= dividend[63:32];
      quo <= dividend[31:0];
      den <= divisor;
    end else if (busy) begin
      rem <= ge ? sub[31:0] : shifted[31:0];
      quo <= {quo[30:0], ge};
    end
  end

  assign quotient = quo;
  assign stat = '{busy: busy, done: done};
endmodule

/* sim/dccr_chain_checker.sv */
`timescale 1ns / 100ps
// ---------------------------------------------------------------------------
// Distance chain checker
// Watches the configuration, input and node channels. On each input beat it
// works out the node positions and compares every node beat with them.
// ---------------------------------------------------------------------------
module dccr_chain_checker (
  input  logic clk,
  input  logic rst,
  dccr_in_if   in_mon,
  dccr_out_if  out_mon,
  dccr_cfg_if  cfg_mon,
  output int   fail_count,
  output int   nodes_owed
);
  import dccr_pkg::*;

  typedef struct {
    logic [5:0]  index;
    logic [31:0] x;
    logic [31:0] y;
    logic        last;
  } node_beat_t;

  node_beat_t  owed_nodes[$];
  logic [30:0] rest_dist;
  logic [31:0] offs_x;
  logic [31:0] offs_y;
  logic [31:0] spread_scale;
  logic [31:0] pos_x[NODE_COUNT];
  logic [31:0] pos_y[NODE_COUNT];
  logic        laid_out;

  function automatic logic [31:0] qmul(logic [31:0] a, logic [31:0] b);
    longint p;
    p = longint'($signed(a)) * longint'($signed(b));
    return 32'(p >>> 16);
  endfunction

  function automatic logic [63:0] root64(logic [63:0] v);
    logic [63:0] r;
    logic [63:0] b;
    r = 0;
    b = 64'h4000_0000_0000_0000;
    while (b > v) b = b >> 2;
    while (b != 0) begin
      if (v >= r + b) begin
        v = v - (r + b);
        r = (r >> 1) + b;
      end else begin
        r = r >> 1;
      end
      b = b >> 2;
    end
    return r;
  endfunction

  task automatic relax_link(int j, bit both);
    logic [31:0] tx;
    logic [31:0] ty;
    longint dx;
    longint dy;
    longint pair_len;
    longint gap;
    logic [63:0] ax;
    logic [63:0] ay;
    logic [31:0] mx;
    logic [31:0] my;
    tx = pos_x[j] - pos_x[j-1];
    ty = pos_y[j] - pos_y[j-1];
    dx = longint'($signed(tx));
    dy = longint'($signed(ty));
    ax = (dx < 0) ? -dx : dx;
    ay = (dy < 0) ? -dy : dy;
    pair_len = longint'(root64(ax * ax + ay * ay));
    if (pair_len < 65536) begin
      dx = 65536;
      dy = 0;
      pair_len = 65536;
    end
    gap = longint'({1'b0, rest_dist}) - pair_len;
    mx = 32'((dx * gap) / pair_len);
    my = 32'((dy * gap) / pair_len);
    pos_x[j] = pos_x[j] + mx;
    pos_y[j] = pos_y[j] + my;
    if (both) begin
      pos_x[j-1] = pos_x[j-1] - mx;
      pos_y[j-1] = pos_y[j-1] - my;
    end
  endtask

  task automatic predict_chain(logic act, logic [31:0] ax, logic [31:0] ay,
                               logic [31:0] sx, logic [31:0] sy);
    logic [31:0] hx;
    logic [31:0] hy;
    logic [31:0] span;
    node_beat_t nb;
    hx = ax + qmul(offs_x, sx);
    hy = ay + qmul(offs_y, sy);
    if (act) begin
      for (int i = 0; i < NODE_COUNT; i++) begin
        span = 32'(i) * 32'(SPACING_MUL) * {1'b0, rest_dist};
        pos_x[i] = hx - qmul(span, spread_scale);
        pos_y[i] = hy;
      end
      laid_out = 1'b1;
    end else begin
      if (!laid_out) return;
      pos_x[0] = hx;
      pos_y[0] = hy;
      for (int p = 0; p < PASS_COUNT; p++)
        for (int j = 1; j < NODE_COUNT; j++) relax_link(j, p != 0);
    end
    for (int i = 0; i < NODE_COUNT; i++) begin
      nb.index = 6'(i);
      nb.x = pos_x[i];
      nb.y = pos_y[i];
      nb.last = (i == NODE_COUNT - 1);
      owed_nodes.push_back(nb);
    end
  endtask

  initial fail_count = 0;

  always @(posedge clk) begin
    node_beat_t exp_nb;
    if (rst) begin
      rest_dist = 31'd65536;
      offs_x = '0;
      offs_y = '0;
      spread_scale = ONE_FX;
      laid_out = 1'b0;
    end else begin
      if (cfg_mon.valid && cfg_mon.ready) begin
        if (cfg_mon.index == CFG_REST_DISTANCE) rest_dist = cfg_mon.data[30:0];
        else if (cfg_mon.index == CFG_OFFSET_X) offs_x = cfg_mon.data;
        else if (cfg_mon.index == CFG_OFFSET_Y) offs_y = cfg_mon.data;
        else if (cfg_mon.index == CFG_SPACING_SCALE) spread_scale = cfg_mon.data;
      end
      if (out_mon.valid && out_mon.ready) begin
        if (owed_nodes.size() == 0) begin
          $display("%0t: unexpected node beat index %0d x %h y %h last %b", $time,
                   out_mon.node_index, out_mon.node_x, out_mon.node_y, out_mon.last_node);
          fail_count++;
        end else begin
          exp_nb = owed_nodes.pop_front();
          if (out_mon.node_index !== exp_nb.index || out_mon.node_x !== exp_nb.x ||
              out_mon.node_y !== exp_nb.y || out_mon.last_node !== exp_nb.last) begin
            $display("%0t: node mismatch expected idx %0d x %h y %h last %b", $time,
                     exp_nb.index, exp_nb.x, exp_nb.y, exp_nb.last);
            $display("%0t:                 actual idx %0d x %h y %h last %b", $time,
                     out_mon.node_index, out_mon.node_x, out_mon.node_y,
                     out_mon.last_node);
            fail_count++;
          end
        end
      end
      if (in_mon.valid && in_mon.ready)
        predict_chain(in_mon.action, in_mon.anchor_x, in_mon.anchor_y,
                      in_mon.owner_scale_x, in_mon.owner_scale_y);
    end
    nodes_owed = owed_nodes.size();
  end
endmodule

/* sim/tb_top.sv */
`timescale 1ns / 100ps
// ---------------------------------------------------------------------------
// Distance chain testbench
// Drives directed and random initialize and tick beats through several
// register settings and idling patterns; the checker judges every node beat.
// ---------------------------------------------------------------------------
module tb_top;
  import dccr_pkg::*;

  localparam int CYCLE_LIMIT = 3_000_000;
  localparam int SETTLE_CYCLES = 6000;
  localparam logic [7:0] CFG_SPARE_IDX = 8'd9;
  localparam logic ACT_TICK = 1'b0;
  localparam logic ACT_INIT = 1'b1;

  logic clk = 1'b0;
  logic rst = 1'b1;
  int   fail_count;
  int   nodes_owed;
  int   cycle_count = 0;
  int   src_idle = 0;
  int   sink_stall = 0;
  logic [31:0] walk_x = 0;
  logic [31:0] walk_y = 0;

  dccr_in_if  in_ch ();
  dccr_out_if out_ch ();
  dccr_cfg_if cfg_ch ();

  distance_constraint_chain_relax_unit dut (
    .clk(clk), .rst(rst), .in_ch(in_ch), .out_ch(out_ch), .cfg_ch(cfg_ch)
  );

  dccr_chain_checker u_checker (
    .clk(clk), .rst(rst), .in_mon(in_ch), .out_mon(out_ch), .cfg_mon(cfg_ch),
    .fail_count(fail_count), .nodes_owed(nodes_owed)
  );

  always #2 clk = ~clk;

  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("TEST FAILED");
      $finish;
    end
  end

  always @(negedge clk) begin
    out_ch.ready <= !rst && ($urandom_range(99) >= sink_stall);
  end

  task automatic send_beat(logic act, logic [31:0] ax, logic [31:0] ay,
                           logic [31:0] sx, logic [31:0] sy);
    logic taken;
    while ($urandom_range(99) < src_idle) begin
      in_ch.valid <= 1'b0;
      @(negedge clk);
    end
    in_ch.valid <= 1'b1;
    in_ch.action <= act;
    in_ch.anchor_x <= ax;
    in_ch.anchor_y <= ay;
    in_ch.owner_scale_x <= sx;
    in_ch.owner_scale_y <= sy;
    taken = 1'b0;
    while (!taken) begin
      taken = in_ch.ready;
      @(posedge clk);
    end
    @(negedge clk);
  endtask

  task automatic write_reg(logic [7:0] idx, logic [31:0] val);
    cfg_ch.valid <= 1'b1;
    cfg_ch.index <= idx;
    cfg_ch.data <= val;
    do @(posedge clk); while (!cfg_ch.ready);
    @(negedge clk);
    cfg_ch.valid <= 1'b0;
  endtask

  task automatic settle;
    in_ch.valid <= 1'b0;
    while (nodes_owed != 0) @(negedge clk);
    repeat (SETTLE_CYCLES) @(negedge clk);
  endtask

  task automatic load_regs(logic [31:0] rest, logic [31:0] ox, logic [31:0] oy,
                           logic [31:0] sc);
    settle();
    write_reg(CFG_REST_DISTANCE, rest);
    write_reg(CFG_OFFSET_X, ox);
    write_reg(CFG_OFFSET_Y, oy);
    write_reg(CFG_SPACING_SCALE, sc);
  endtask

  task automatic random_beats(int count);
    logic [31:0] sx;
    logic [31:0] sy;
    for (int n = 0; n < count; n++) begin
      if ($urandom_range(99) < 15) begin
        send_beat(1'($urandom_range(1)), $urandom, $urandom, $urandom, $urandom);
      end else begin
        walk_x = walk_x + 32'($signed($urandom_range(8 << 16)) - (4 << 16));
        walk_y = walk_y + 32'($signed($urandom_range(8 << 16)) - (4 << 16));
        sx = ($urandom_range(1)) ? ONE_FX : 32'($urandom_range(1 << 18)) - (1 << 17);
        sy = ($urandom_range(1)) ? ONE_FX : 32'($urandom_range(1 << 18)) - (1 << 17);
        send_beat(($urandom_range(99) < 8) ? ACT_INIT : ACT_TICK, walk_x, walk_y, sx, sy);
      end
    end
  endtask

  initial begin
    in_ch.valid = 1'b0;
    in_ch.action = ACT_TICK;
    in_ch.anchor_x = '0;
    in_ch.anchor_y = '0;
    in_ch.owner_scale_x = '0;
    in_ch.owner_scale_y = '0;
    cfg_ch.valid = 1'b0;
    cfg_ch.index = '0;
    cfg_ch.data = '0;
    repeat (8) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;
    @(negedge clk);

    send_beat(ACT_TICK, 32'h0001_0000, 32'h0002_0000, ONE_FX, ONE_FX);
    send_beat(ACT_INIT, 32'h0000_0000, 32'h0000_0000, ONE_FX, ONE_FX);
    send_beat(ACT_TICK, 32'h0003_0000, 32'hFFFF_0000, ONE_FX, ONE_FX);
    send_beat(ACT_TICK, 32'h7FFF_FFFF, 32'h8000_0000, 32'h7FFF_FFFF, 32'h8000_0000);
    send_beat(ACT_TICK, 32'h8000_0000, 32'h7FFF_FFFF, 32'h8000_0000, 32'h7FFF_FFFF);
    send_beat(ACT_INIT, 32'hFFFF_FFFF, 32'h0000_0001, 32'hFFFF_FFFF, 32'h0000_0000);
    send_beat(ACT_TICK, 32'h0000_8000, 32'h0000_4000, 32'h0000_0000, 32'hFFFF_FFFF);
    load_regs(32'h0000_0000, 32'h0002_0000, 32'hFFFE_0000, ONE_FX);
    write_reg(CFG_SPARE_IDX, 32'hDEAD_BEEF);
    send_beat(ACT_INIT, 32'h0010_0000, 32'h0020_0000, ONE_FX, ONE_FX);
    send_beat(ACT_TICK, 32'h0010_0000, 32'h0020_0000, ONE_FX, ONE_FX);
    send_beat(ACT_TICK, 32'h0010_8000, 32'h0020_0000, 32'h0000_8000, 32'h0002_0000);
    load_regs(32'hFFFF_FFFF, 32'h7FFF_FFFF, 32'h8000_0000, 32'h8000_0000);
    send_beat(ACT_INIT, 32'h1234_5678, 32'h8765_4321, ONE_FX, ONE_FX);
    send_beat(ACT_TICK, 32'h1234_5678, 32'h8765_4321, 32'h0000_0001, 32'hFFFF_FFFF);
    load_regs(32'h0003_0000, 32'h8000_0000, 32'h7FFF_FFFF, 32'h7FFF_FFFF);
    send_beat(ACT_INIT, 32'h0000_0000, 32'h0000_0000, 32'h0000_1000, 32'h0000_1000);
    send_beat(ACT_TICK, 32'h0001_0000, 32'h0001_0000, 32'h0000_1000, 32'h0000_1000);

    load_regs(32'h0001_8000, 32'h0000_4000, 32'hFFFF_C000, ONE_FX);
    src_idle = 0;
    sink_stall = 0;
    send_beat(ACT_INIT, walk_x, walk_y, ONE_FX, ONE_FX);
    random_beats(24);
    load_regs(32'h0000_4000, 32'h0001_0000, 32'h0000_0000, 32'hFFFF_0000);
    src_idle = 54;
    random_beats(24);
    load_regs(32'($urandom_range(32'h7FFF_FFFF)), $urandom, $urandom, $urandom);
    src_idle = 0;
    sink_stall = 54;
    random_beats(24);
    load_regs(32'h0002_0000, 32'hFFFF_0000, 32'h0000_8000, 32'h0000_C000);
    src_idle = 21;
    sink_stall = 21;
    random_beats(23);

    in_ch.valid <= 1'b0;
    while (nodes_owed != 0) @(negedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
    if (fail_count == 0) begin
      $display("TEST PASSED");
    end else begin
      $display("TEST FAILED");
    end
    $finish;
  end
endmodule
